[rtl/core/kngh_pkg.sv]
package kngh_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned LEVEL_W    = SAMPLE_W - 1;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned GAIN_W     = GAIN_FRAC + 1;
  localparam int unsigned COEFF_W    = GAIN_FRAC;
  localparam int unsigned HOLD_REG_W = 20;
  localparam int unsigned HOLD_W     = HOLD_REG_W + 1;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = LEVEL_W;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [GAIN_W-1:0]  UNITY     = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  // Gate modes
  localparam logic [MODE_W-1:0] MODE_CLOSED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLOSING = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE   = 3'd6;

  // Key classification made by the front
  typedef enum logic [1:0] {
    CLS_PASS  = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_BELOW = 2'd2,
    CLS_ZONE  = 2'd3
  } cls_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]    open_level;
    logic [LEVEL_W-1:0]    close_level;
    logic [COEFF_W-1:0]    attack_coeff;
    logic [COEFF_W-1:0]    release_coeff;
    logic [HOLD_REG_W-1:0] hold_samples;
    logic [GAIN_W-1:0]     floor_gain;
    logic                  gate_enable;
  } cfg_t;

  typedef struct packed {
    cls_e                       cls;
    logic signed [SAMPLE_W-1:0] sig;
    logic                       last;
  } entry_t;

endpackage

[rtl/core/keyed_noise_gate_hold_release_unit.sv]
// Channel  | Dir | Handshake                 | Payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata: key_sample, signal_sample; tlast
// m_axis   | out | m_axis_tvalid/tready      | tdata: out_sample; tuser: gate_mode; tlast
// cfg      | in  | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A word enters a two-deep queue after the key is classified; the envelope update
// (one 16x17 multiply) is made as it leaves the queue into the gain stage register,
// and the gain multiply (24x18) then fills the output register, so a result passes
// the queue, the gain stage and the output register; up to one word per cycle
// while the output is taken.
// Reset clears gate state, queue and valid flags, and loads register defaults.
// Either side may stall; the queue and the output register hold their words.
module keyed_noise_gate_hold_release_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [2*kngh_pkg::SAMPLE_W-1:0]    s_axis_tdata, // key_sample, signal_sample
  input  logic                               s_axis_tlast, // frame_last
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [kngh_pkg::SAMPLE_W-1:0]      m_axis_tdata, // out_sample
  output logic [kngh_pkg::MODE_W-1:0]        m_axis_tuser, // gate_mode
  output logic                               m_axis_tlast, // frame_last_out
  input  logic                               cfg_we_i,
  input  logic [kngh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kngh_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  kngh_pkg::cfg_t   cfg_q;
  kngh_pkg::entry_t push_entry, head;
  logic             push, full, q_valid, pop;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_level    <= kngh_pkg::LEVEL_W'(8388);
      cfg_q.close_level   <= kngh_pkg::LEVEL_W'(4194);
      cfg_q.attack_coeff  <= '0;
      cfg_q.release_coeff <= kngh_pkg::COEFF_W'(65000);
      cfg_q.hold_samples  <= kngh_pkg::HOLD_REG_W'(2205);
      cfg_q.floor_gain    <= '0;
      cfg_q.gate_enable   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kngh_pkg::REG_OPEN_LEVEL:    cfg_q.open_level    <= cfg_wdata_i;
        kngh_pkg::REG_CLOSE_LEVEL:   cfg_q.close_level   <= cfg_wdata_i;
        kngh_pkg::REG_ATTACK_COEFF:
          cfg_q.attack_coeff  <= cfg_wdata_i[kngh_pkg::COEFF_W-1:0];
        kngh_pkg::REG_RELEASE_COEFF:
          cfg_q.release_coeff <= cfg_wdata_i[kngh_pkg::COEFF_W-1:0];
        kngh_pkg::REG_HOLD_SAMPLES:
          cfg_q.hold_samples  <= cfg_wdata_i[kngh_pkg::HOLD_REG_W-1:0];
        kngh_pkg::REG_FLOOR_GAIN:
          cfg_q.floor_gain    <= cfg_wdata_i[kngh_pkg::GAIN_W-1:0];
        kngh_pkg::REG_GATE_ENABLE:   cfg_q.gate_enable   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  kngh_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_i         (cfg_q),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (full)
  );

  kngh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  kngh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[rtl/core/kngh_front.sv]
module kngh_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*kngh_pkg::SAMPLE_W-1:0] s_axis_tdata, // key_sample, signal_sample
  input  logic                          s_axis_tlast,  // frame_last
  input  kngh_pkg::cfg_t                cfg_i,
  output logic                          push_o,
  output kngh_pkg::entry_t              entry_o,
  input  logic                          full_i
);

  logic [kngh_pkg::SAMPLE_W-1:0] key;
  logic [kngh_pkg::SAMPLE_W-1:0] key_abs;
  logic [kngh_pkg::LEVEL_W-1:0]  mag;

  assign key = s_axis_tdata[kngh_pkg::SAMPLE_W-1:0];

  // Key magnitude, most negative key saturates to the largest positive sample
  assign key_abs = key[kngh_pkg::SAMPLE_W-1] ? (~key + 1'b1) : key;
  assign mag     = key_abs[kngh_pkg::SAMPLE_W-1] ? kngh_pkg::LEVEL_MAX
                                                 : key_abs[kngh_pkg::LEVEL_W-1:0];

  // Classify: pass when the gate is disabled, else open test first, then close level, else hysteresis zone
  always_comb begin
    entry_o.sig  = s_axis_tdata[2*kngh_pkg::SAMPLE_W-1:kngh_pkg::SAMPLE_W];
    entry_o.last = s_axis_tlast;
    if (!cfg_i.gate_enable) begin
      entry_o.cls = kngh_pkg::CLS_PASS;
    end else if (mag >= cfg_i.open_level) begin
      entry_o.cls = kngh_pkg::CLS_OPEN;
    end else if (mag < cfg_i.close_level) begin
      entry_o.cls = kngh_pkg::CLS_BELOW;
    end else begin
      entry_o.cls = kngh_pkg::CLS_ZONE;
    end
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

endmodule

[rtl/core/kngh_queue.sv]
module kngh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kngh_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output kngh_pkg::entry_t head_o
);

  kngh_pkg::entry_t                mem_q [kngh_pkg::QUEUE_DEPTH];
  logic [kngh_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [kngh_pkg::QCNT_W-1:0]     count_q;

  assign full_o  = (count_q == kngh_pkg::QCNT_W'(kngh_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Word storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == kngh_pkg::QPTR_W'(kngh_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == kngh_pkg::QPTR_W'(kngh_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Never more words than slots, and no pop of an empty queue
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kngh_pkg::QCNT_W'(kngh_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

[rtl/core/kngh_back.sv]
module kngh_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kngh_pkg::cfg_t                cfg_i,
  input  logic                          q_valid_i,
  input  kngh_pkg::entry_t              head_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kngh_pkg::SAMPLE_W-1:0] m_axis_tdata, // out_sample
  output logic [kngh_pkg::MODE_W-1:0]   m_axis_tuser, // gate_mode
  output logic                          m_axis_tlast  // frame_last_out
);

  localparam int unsigned EPROD_W = kngh_pkg::COEFF_W + kngh_pkg::GAIN_W;
  localparam int unsigned GPROD_W = kngh_pkg::SAMPLE_W + kngh_pkg::GAIN_W + 1;

  // Gate state
  logic [kngh_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [kngh_pkg::GAIN_W-1:0] env_q, env_d;
  logic [kngh_pkg::HOLD_W-1:0] hold_q, hold_d;

  // Gain stage
  logic                               p_valid_q;
  logic                               p_pass_q;
  logic signed [kngh_pkg::SAMPLE_W-1:0] p_sig_q;
  logic                               p_last_q;

  // Output register
  logic                          out_valid_q;
  logic [kngh_pkg::SAMPLE_W-1:0] out_sample_q;
  logic [kngh_pkg::MODE_W-1:0]   out_mode_q;
  logic                          out_last_q;

  logic                          p_adv;
  logic [kngh_pkg::GAIN_W-1:0]   floor_v;
  logic [kngh_pkg::COEFF_W-1:0]  coeff;
  logic [EPROD_W-1:0]            env_prod;
  logic [kngh_pkg::GAIN_W-1:0]   env_scaled;
  logic [kngh_pkg::GAIN_W-1:0]   attack_env;
  logic                          hold_done;
  logic signed [GPROD_W-1:0]     gain_prod;

  assign p_adv = p_valid_q && (!out_valid_q || m_axis_tready);
  assign pop_o = q_valid_i && (!p_valid_q || p_adv);

  // Floor gain clamped to unity
  assign floor_v = (cfg_i.floor_gain > kngh_pkg::UNITY) ? kngh_pkg::UNITY
                                                        : cfg_i.floor_gain;

  // One multiplier serves both attack and release
  assign coeff      = (head_i.cls == kngh_pkg::CLS_OPEN) ? cfg_i.attack_coeff
                                                         : cfg_i.release_coeff;
  assign env_prod   = {{kngh_pkg::GAIN_W{1'b0}}, coeff} *
                      {{kngh_pkg::COEFF_W{1'b0}}, env_q};
  assign env_scaled = env_prod[EPROD_W-1:kngh_pkg::GAIN_FRAC];
  assign attack_env = (kngh_pkg::UNITY - {1'b0, cfg_i.attack_coeff}) + env_scaled;
  assign hold_done  = (hold_q <= kngh_pkg::HOLD_W'(1));

  // Envelope, hold and mode update for the word leaving the queue
  always_comb begin
    mode_d = mode_q;
    env_d  = env_q;
    hold_d = hold_q;
    if (pop_o) begin
      unique case (head_i.cls)
        kngh_pkg::CLS_PASS: begin
        end
        kngh_pkg::CLS_OPEN: begin
          mode_d = kngh_pkg::MODE_OPEN;
          hold_d = {1'b0, cfg_i.hold_samples};
          env_d  = attack_env;
        end
        kngh_pkg::CLS_BELOW: begin
          case (mode_q) inside
            kngh_pkg::MODE_OPEN, kngh_pkg::MODE_HOLD: begin
              mode_d = hold_done ? kngh_pkg::MODE_CLOSING : kngh_pkg::MODE_HOLD;
              hold_d = hold_done ? '0 : hold_q - 1'b1;
            end
            kngh_pkg::MODE_CLOSING: begin
              env_d = env_scaled;
              if (env_scaled < floor_v) begin
                env_d  = floor_v;
                mode_d = kngh_pkg::MODE_CLOSED;
              end
            end
            default: begin
              env_d = floor_v;
            end
          endcase
        end
        kngh_pkg::CLS_ZONE: begin
          case (mode_q)
            kngh_pkg::MODE_HOLD: begin
              mode_d = hold_done ? kngh_pkg::MODE_CLOSING : kngh_pkg::MODE_HOLD;
              hold_d = hold_done ? '0 : hold_q - 1'b1;
            end
            kngh_pkg::MODE_CLOSING: begin
              env_d = env_scaled;
              if (env_scaled < floor_v) begin
                env_d  = floor_v;
                mode_d = kngh_pkg::MODE_CLOSED;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      // a zero envelope snaps to the floor, except on pass words
      if ((head_i.cls != kngh_pkg::CLS_PASS) && (env_d == '0)) begin
        env_d = floor_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kngh_pkg::MODE_CLOSED;
      env_q  <= '0;
      hold_q <= '0;
    end else begin
      mode_q <= mode_d;
      env_q  <= env_d;
      hold_q <= hold_d;
    end
  end

  // Gain stage holds the sample while the envelope settles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (pop_o) begin
      p_valid_q <= 1'b1;
    end else if (p_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_pass_q <= (head_i.cls == kngh_pkg::CLS_PASS);
      p_sig_q  <= head_i.sig;
      p_last_q <= head_i.last;
    end
  end

  // Signed sample times unsigned gain, arithmetic shift floors the result
  assign gain_prod = $signed({{(GPROD_W-kngh_pkg::SAMPLE_W){p_sig_q[kngh_pkg::SAMPLE_W-1]}},
                              p_sig_q})
                   * $signed({{(GPROD_W-kngh_pkg::GAIN_W){1'b0}}, env_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      out_sample_q <= p_pass_q ? p_sig_q
                    : gain_prod[kngh_pkg::GAIN_FRAC+kngh_pkg::SAMPLE_W-1:kngh_pkg::GAIN_FRAC];
      out_mode_q   <= mode_q;
      out_last_q   <= p_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_mode_q;
  assign m_axis_tlast  = out_last_q;

  // Envelope never rises above unity
  a_env_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= kngh_pkg::UNITY)
    else $error("envelope above unity");

  // A running hold count only exists while open or holding
  a_hold_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q != '0) |-> (mode_q == kngh_pkg::MODE_OPEN || mode_q == kngh_pkg::MODE_HOLD))
    else $error("hold count outside open or hold");

  // A new result only comes from an occupied gain stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(p_valid_q))
    else $error("result without gain stage word");

endmodule
